/* src/lc3ie_pkg.sv */
// Shared types, opcodes and helper functions for the LC-3 instruction execute block.
// Used by the register file, the word memory and the top level; no dependencies.
package lc3ie_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;
	localparam int WORD_W = 16;
	localparam int REG_IDX_W = 3;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 96;

	// command codes carried on the input stream
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SET_PC = 2'd2,
		CMD_EXEC   = 2'd3
	} cmd_t;

	// instruction opcodes, bits 15:12
	typedef enum logic [3:0] {
		OP_BR   = 4'd0,
		OP_ADD  = 4'd1,
		OP_LD   = 4'd2,
		OP_ST   = 4'd3,
		OP_JSR  = 4'd4,
		OP_AND  = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_RTI  = 4'd8,
		OP_NOT  = 4'd9,
		OP_LDI  = 4'd10,
		OP_STI  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RES  = 4'd13,
		OP_LEA  = 4'd14,
		OP_TRAP = 4'd15
	} opcode_t;

	localparam logic [2:0] FLAG_N = 3'b100;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_P = 3'b001;

	localparam logic [REG_IDX_W-1:0] LINK_REG = 3'd7;

	// register file write request
	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] num;
		logic [WORD_W-1:0]    value;
	} rf_wr_t;

	function automatic logic [WORD_W-1:0] sext5(input logic [WORD_W-1:0] ir);
		return {{11{ir[4]}}, ir[4:0]};
	endfunction

	function automatic logic [WORD_W-1:0] sext6(input logic [WORD_W-1:0] ir);
		return {{10{ir[5]}}, ir[5:0]};
	endfunction

	function automatic logic [WORD_W-1:0] sext9(input logic [WORD_W-1:0] ir);
		return {{7{ir[8]}}, ir[8:0]};
	endfunction

	function automatic logic [WORD_W-1:0] sext11(input logic [WORD_W-1:0] ir);
		return {{5{ir[10]}}, ir[10:0]};
	endfunction

	// exactly one condition code from the sign and zero-ness of a value
	function automatic logic [2:0] cond_code(input logic [WORD_W-1:0] v);
		logic [2:0] cc;
		if (v[WORD_W-1]) begin
			cc = FLAG_N;
		end else if (v == '0) begin
			cc = FLAG_Z;
		end else begin
			cc = FLAG_P;
		end
		return cc;
	endfunction

endpackage

/* src/lc3_instruction_execute.sv */
// LC-3 execute block: input skid stage, sequencer, register file and word memory.
// Depends on lc3ie_pkg, lc3ie_reg_file and lc3ie_word_mem.
//
// Usage: each transfer on the s_axis channel is one command (write a memory word,
// read a memory word, set the PC, or execute one instruction word). Every command
// gives exactly one result transfer on the m_axis channel with the PC, condition
// codes, read word, register and store reports, and the illegal and halted bits.
// Each command waits in the input stage, then the sequencer picks it up, issues its
// reads, executes it and registers the result; LDR and LDI need a second dependent
// memory read. Memory and register file reads are registered (issue a read,
// then use its data). An input stage takes the next command while the current one
// executes, and the output register is reloaded in the same cycle as its previous
// result transfers.
// Reset: registers read as zero, PC is zero, condition codes show Z, the halted
// bit is clear; word memory contents are undefined until written.
// Stall: while m_axis_tready is low and a result is pending, the sequencer holds at
// its last step and the input stage fills, then s_axis_tready drops.
// An RTI or reserved opcode reports illegal and halts execution until reset;
// memory and set-pc commands still act while halted.
module lc3_instruction_execute #(
	parameter int MEM_ADDR_BITS = lc3ie_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// command[1:0], address[17:2], data[33:18], zero fill above
	input  logic [lc3ie_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pc_after[15:0], flags_nzp[18:16], read_word[34:19], reg_written[35],
	// reg_number[38:36], reg_value[54:39], mem_written[55], store_address[71:56],
	// store_value[87:72], illegal[88], halted[89], zero fill above
	output logic [lc3ie_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int W = lc3ie_pkg::WORD_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_MEM2 = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// input skid stage
	logic                in_fire;
	logic                inb_valid_q;
	lc3ie_pkg::cmd_t     inb_cmd_q;
	logic [W-1:0]        inb_addr_q;
	logic [W-1:0]        inb_data_q;

	// command in the engine
	lc3ie_pkg::cmd_t     cmd_s1;
	logic [W-1:0]        addr_s1;
	logic [W-1:0]        ir_s1;

	// architectural state
	logic [W-1:0]        pc_q;
	logic [2:0]          flags_q;
	logic                stopped_q;

	// output register
	logic                          out_valid_q;
	logic [lc3ie_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                          out_ok;

	// memory and register file ports
	logic                start;
	lc3ie_pkg::opcode_t  inb_op;
	logic [W-1:0]        start_rd_addr;
	logic                mem_rd_en;
	logic [W-1:0]        mem_rd_addr;
	logic [W-1:0]        mem_rd_data;
	logic                mem_wr_en;
	logic [W-1:0]        mem_wr_addr;
	logic [W-1:0]        mem_wr_data;
	logic [lc3ie_pkg::REG_IDX_W-1:0] rf_addr_b;
	logic [W-1:0]        ra;
	logic [W-1:0]        rb;
	lc3ie_pkg::rf_wr_t   rf_wr;

	// execution results
	lc3ie_pkg::opcode_t  op;
	logic [W-1:0]        pc_inc;
	logic [W-1:0]        pc_rel;
	logic [W-1:0]        base_rel;
	logic [W-1:0]        op2;
	logic                exec;
	logic                go_mem2;
	logic                fin;
	logic [W-1:0]        pc_nxt;
	logic [2:0]          flags_nxt;
	logic                stop_nxt;
	logic [W-1:0]        rd_word;
	logic                rw;
	logic [lc3ie_pkg::REG_IDX_W-1:0] rn;
	logic [W-1:0]        rv;
	logic                set_cc;
	logic                mw;
	logic [W-1:0]        sa;
	logic [W-1:0]        sv;
	logic                ill;
	logic                second_rd;
	logic [W-1:0]        second_addr;

	// handshake
	assign start         = (state_q == ST_IDLE) && inb_valid_q;
	assign s_axis_tready = !inb_valid_q || start;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_ok        = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inb_valid_q <= 1'b0;
		end else if (in_fire) begin
			inb_valid_q <= 1'b1;
		end else if (start) begin
			inb_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			inb_cmd_q  <= lc3ie_pkg::cmd_t'(s_axis_tdata[1:0]);
			inb_addr_q <= s_axis_tdata[17:2];
			inb_data_q <= s_axis_tdata[33:18];
		end
		if (start) begin
			cmd_s1  <= inb_cmd_q;
			addr_s1 <= inb_addr_q;
			ir_s1   <= inb_data_q;
		end
	end

	// first reads issued as the engine picks up a command
	assign inb_op = lc3ie_pkg::opcode_t'(inb_data_q[15:12]);

	always_comb begin
		if (inb_cmd_q == lc3ie_pkg::CMD_READ) begin
			start_rd_addr = inb_addr_q;
		end else if (inb_op == lc3ie_pkg::OP_TRAP) begin
			start_rd_addr = {8'h00, inb_data_q[7:0]};
		end else begin
			start_rd_addr = pc_q + 16'd1 + lc3ie_pkg::sext9(inb_data_q);
		end
	end

	assign rf_addr_b = (inb_op == lc3ie_pkg::OP_ST || inb_op == lc3ie_pkg::OP_STR ||
			inb_op == lc3ie_pkg::OP_STI) ? inb_data_q[11:9] : inb_data_q[2:0];

	assign mem_rd_en   = start || second_rd;
	assign mem_rd_addr = start ? start_rd_addr : second_addr;

	// command writes at pickup, instruction stores when the command finishes
	assign mem_wr_en   = (start && inb_cmd_q == lc3ie_pkg::CMD_WRITE) || (mw && fin);
	assign mem_wr_addr = start ? inb_addr_q : sa;
	assign mem_wr_data = start ? inb_data_q : sv;

	lc3ie_word_mem #(
		.AW (MEM_ADDR_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr[MEM_ADDR_BITS-1:0]),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr[MEM_ADDR_BITS-1:0]),
		.wr_data (mem_wr_data)
	);

	assign rf_wr.en    = rw && fin;
	assign rf_wr.num   = rn;
	assign rf_wr.value = rv;

	lc3ie_reg_file u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (start),
		.rd_addr_a (inb_data_q[8:6]),
		.rd_addr_b (rf_addr_b),
		.rd_data_a (ra),
		.rd_data_b (rb),
		.wr        (rf_wr)
	);

	// instruction datapath
	assign op       = lc3ie_pkg::opcode_t'(ir_s1[15:12]);
	assign pc_inc   = pc_q + 16'd1;
	assign pc_rel   = pc_inc + lc3ie_pkg::sext9(ir_s1);
	assign base_rel = ra + lc3ie_pkg::sext6(ir_s1);
	assign op2      = ir_s1[5] ? lc3ie_pkg::sext5(ir_s1) : rb;
	assign exec     = (cmd_s1 == lc3ie_pkg::CMD_EXEC) && !stopped_q;

	always_comb begin
		pc_nxt      = pc_q;
		stop_nxt    = stopped_q;
		rd_word     = '0;
		rw          = 1'b0;
		rn          = '0;
		rv          = '0;
		set_cc      = 1'b0;
		mw          = 1'b0;
		sa          = '0;
		sv          = '0;
		ill         = 1'b0;
		go_mem2     = 1'b0;
		second_rd   = 1'b0;
		second_addr = base_rel;
		if (state_q == ST_MEM2) begin
			// second read of LDR or LDI has returned
			pc_nxt = pc_inc;
			rw     = 1'b1;
			rn     = ir_s1[11:9];
			rv     = mem_rd_data;
			set_cc = 1'b1;
		end else if (state_q == ST_EXEC) begin
			unique case (cmd_s1)
				lc3ie_pkg::CMD_WRITE: begin
				end
				lc3ie_pkg::CMD_READ: begin
					rd_word = mem_rd_data;
				end
				lc3ie_pkg::CMD_SET_PC: begin
					pc_nxt = addr_s1;
				end
				lc3ie_pkg::CMD_EXEC: begin
					if (exec) begin
						pc_nxt = pc_inc;
						unique case (op)
							lc3ie_pkg::OP_BR: begin
								if ((ir_s1[11:9] & flags_q) != 3'b000) begin
									pc_nxt = pc_rel;
								end
							end
							lc3ie_pkg::OP_ADD: begin
								rw = 1'b1; rn = ir_s1[11:9]; rv = ra + op2; set_cc = 1'b1;
							end
							lc3ie_pkg::OP_AND: begin
								rw = 1'b1; rn = ir_s1[11:9]; rv = ra & op2; set_cc = 1'b1;
							end
							lc3ie_pkg::OP_NOT: begin
								rw = 1'b1; rn = ir_s1[11:9]; rv = ~ra; set_cc = 1'b1;
							end
							lc3ie_pkg::OP_LD: begin
								rw = 1'b1; rn = ir_s1[11:9]; rv = mem_rd_data; set_cc = 1'b1;
							end
							lc3ie_pkg::OP_ST: begin
								mw = 1'b1; sa = pc_rel; sv = rb;
							end
							lc3ie_pkg::OP_LDR: begin
								go_mem2     = 1'b1;
								second_rd   = 1'b1;
								second_addr = base_rel;
							end
							lc3ie_pkg::OP_STR: begin
								mw = 1'b1; sa = base_rel; sv = rb;
							end
							lc3ie_pkg::OP_LDI: begin
								go_mem2     = 1'b1;
								second_rd   = 1'b1;
								second_addr = mem_rd_data;
							end
							lc3ie_pkg::OP_STI: begin
								mw = 1'b1; sa = mem_rd_data; sv = rb;
							end
							lc3ie_pkg::OP_LEA: begin
								rw = 1'b1; rn = ir_s1[11:9]; rv = pc_rel; set_cc = 1'b1;
							end
							lc3ie_pkg::OP_JMP: begin
								pc_nxt = ra;
							end
							lc3ie_pkg::OP_JSR: begin
								pc_nxt = ir_s1[11] ? (pc_inc + lc3ie_pkg::sext11(ir_s1)) : ra;
								rw     = 1'b1;
								rn     = lc3ie_pkg::LINK_REG;
								rv     = pc_inc;
							end
							lc3ie_pkg::OP_TRAP: begin
								pc_nxt = mem_rd_data;
								rw     = 1'b1;
								rn     = lc3ie_pkg::LINK_REG;
								rv     = pc_inc;
							end
							lc3ie_pkg::OP_RTI, lc3ie_pkg::OP_RES: begin
								ill      = 1'b1;
								stop_nxt = 1'b1;
							end
						endcase
					end
				end
			endcase
		end
		flags_nxt = set_cc ? lc3ie_pkg::cond_code(rv) : flags_q;
	end

	// sequencer
	assign fin = ((state_q == ST_EXEC && !go_mem2) || state_q == ST_MEM2) && out_ok;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go_mem2) begin
					state_nxt = ST_MEM2;
				end else if (fin) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_MEM2: begin
				if (fin) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			flags_q     <= lc3ie_pkg::FLAG_Z;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fin) begin
				pc_q        <= pc_nxt;
				flags_q     <= flags_nxt;
				stopped_q   <= stop_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q <= {6'b000000, stop_nxt, ill, sv, sa, mw, rv, rn, rw, rd_word,
					flags_nxt, pc_nxt};
		end
	end

endmodule

/* src/lc3ie_word_mem.sv */
// Word memory of the execute block: one write port, one read port, registered read data.
// Depends on lc3ie_pkg for the word width.
module lc3ie_word_mem #(
	parameter int AW = lc3ie_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [lc3ie_pkg::WORD_W-1:0]  rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [lc3ie_pkg::WORD_W-1:0]  wr_data
);

	logic [lc3ie_pkg::WORD_W-1:0] mem [2**AW];
	logic [lc3ie_pkg::WORD_W-1:0] rd_data_q;

	// synchronous write and read, read data held until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/lc3ie_reg_file.sv */
// Eight-entry general register file: two registered read ports and one write port.
// Entries not yet written read as zero through per-entry valid bits. Depends on lc3ie_pkg.
module lc3ie_reg_file (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [lc3ie_pkg::REG_IDX_W-1:0]     rd_addr_a,
	input  logic [lc3ie_pkg::REG_IDX_W-1:0]     rd_addr_b,
	output logic [lc3ie_pkg::WORD_W-1:0]        rd_data_a,
	output logic [lc3ie_pkg::WORD_W-1:0]        rd_data_b,
	input  lc3ie_pkg::rf_wr_t                   wr
);

	localparam int DEPTH = 2**lc3ie_pkg::REG_IDX_W;

	logic [lc3ie_pkg::WORD_W-1:0] regs [DEPTH];
	logic [DEPTH-1:0]             valid_q;
	logic [lc3ie_pkg::WORD_W-1:0] a_data_q;
	logic [lc3ie_pkg::WORD_W-1:0] b_data_q;
	logic                         a_ok_q;
	logic                         b_ok_q;

	// storage and registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			regs[wr.num] <= wr.value;
		end
		if (rd_en) begin
			a_data_q <= regs[rd_addr_a];
			b_data_q <= regs[rd_addr_b];
		end
	end

	// valid bits, cleared by reset so every register starts at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			a_ok_q  <= 1'b0;
			b_ok_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.num] <= 1'b1;
			end
			if (rd_en) begin
				a_ok_q <= valid_q[rd_addr_a];
				b_ok_q <= valid_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = a_ok_q ? a_data_q : '0;
	assign rd_data_b = b_ok_q ? b_data_q : '0;

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for lc3_instruction_execute: an LC-3 architectural predictor
// and random command streams with idling on both sides. Depends on lc3ie_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [lc3ie_pkg::WORD_W-1:0] word_t;

	// result transfer layout, top bits are zero fill
	typedef struct packed {
		logic [5:0]  fill;
		logic        halted;
		logic        illegal;
		word_t       store_value;
		word_t       store_address;
		logic        mem_written;
		word_t       reg_value;
		logic [2:0]  reg_number;
		logic        reg_written;
		word_t       read_word;
		logic [2:0]  flags_nzp;
		word_t       pc_after;
	} exec_report_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_SHOWN = 40;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [lc3ie_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [lc3ie_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// architectural copy kept by the predictor
	word_t      arch_reg [0:7];
	word_t      arch_pc;
	logic [2:0] arch_nzp;
	bit         arch_halted;
	word_t      mem_img [0:65535];
	bit         mem_set [0:65535];
	word_t      written_addrs [$];

	exec_report_t expected_reports [$];

	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_exec = 0;
	int unsigned n_reg_wr = 0;
	int unsigned n_store = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_request = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_stalls_on = 1'b1;

	lc3_instruction_execute i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic word_t sx(word_t v, int unsigned bits);
		word_t m;
		m = 16'hFFFF >> (16 - bits);
		v = v & m;
		if (v[bits-1]) begin
			v = v | ~m;
		end
		return v;
	endfunction

	function automatic void note_store(word_t a, word_t v);
		if (!mem_set[a]) begin
			written_addrs.push_back(a);
		end
		mem_set[a] = 1'b1;
		mem_img[a] = v;
	endfunction

	function automatic void put_reg(logic [2:0] num, word_t v, bit set_cc,
			inout exec_report_t rep);
		arch_reg[num] = v;
		rep.reg_written = 1'b1;
		rep.reg_number = num;
		rep.reg_value = v;
		n_reg_wr++;
		if (set_cc) begin
			arch_nzp = v[15] ? lc3ie_pkg::FLAG_N :
				(v == '0 ? lc3ie_pkg::FLAG_Z : lc3ie_pkg::FLAG_P);
		end
	endfunction

	function automatic void put_mem(word_t a, word_t v, inout exec_report_t rep);
		note_store(a, v);
		rep.mem_written = 1'b1;
		rep.store_address = a;
		rep.store_value = v;
		n_store++;
	endfunction

	// one instruction on the architectural state, pc pointing at it on entry
	function automatic void run_instr(word_t ir, inout exec_report_t rep);
		lc3ie_pkg::opcode_t op;
		logic [2:0] dr;
		logic [2:0] sr1;
		word_t      nxt;
		word_t      ea_pc;
		word_t      ea_base;
		word_t      opnd;
		word_t      tgt;
		op = lc3ie_pkg::opcode_t'(ir[15:12]);
		dr = ir[11:9];
		sr1 = ir[8:6];
		nxt = arch_pc + 16'd1;
		ea_pc = nxt + sx(ir, 9);
		ea_base = arch_reg[sr1] + sx(ir, 6);
		opnd = ir[5] ? sx(ir, 5) : arch_reg[ir[2:0]];
		arch_pc = nxt;
		n_exec++;
		case (op)
			lc3ie_pkg::OP_BR: begin
				if ((dr & arch_nzp) != '0) begin
					arch_pc = ea_pc;
				end
			end
			lc3ie_pkg::OP_ADD:  put_reg(dr, arch_reg[sr1] + opnd, 1'b1, rep);
			lc3ie_pkg::OP_AND:  put_reg(dr, arch_reg[sr1] & opnd, 1'b1, rep);
			lc3ie_pkg::OP_NOT:  put_reg(dr, ~arch_reg[sr1], 1'b1, rep);
			lc3ie_pkg::OP_LD:   put_reg(dr, mem_img[ea_pc], 1'b1, rep);
			lc3ie_pkg::OP_ST:   put_mem(ea_pc, arch_reg[dr], rep);
			lc3ie_pkg::OP_LDR:  put_reg(dr, mem_img[ea_base], 1'b1, rep);
			lc3ie_pkg::OP_STR:  put_mem(ea_base, arch_reg[dr], rep);
			lc3ie_pkg::OP_LDI:  put_reg(dr, mem_img[mem_img[ea_pc]], 1'b1, rep);
			lc3ie_pkg::OP_STI:  put_mem(mem_img[ea_pc], arch_reg[dr], rep);
			lc3ie_pkg::OP_LEA:  put_reg(dr, ea_pc, 1'b1, rep);
			lc3ie_pkg::OP_JMP:  arch_pc = arch_reg[sr1];
			lc3ie_pkg::OP_JSR: begin
				// target taken before the link register is written
				tgt = ir[11] ? nxt + sx(ir, 11) : arch_reg[sr1];
				put_reg(lc3ie_pkg::LINK_REG, nxt, 1'b0, rep);
				arch_pc = tgt;
			end
			lc3ie_pkg::OP_TRAP: begin
				tgt = mem_img[{8'h00, ir[7:0]}];
				put_reg(lc3ie_pkg::LINK_REG, nxt, 1'b0, rep);
				arch_pc = tgt;
			end
			default: begin
				// rti and reserved: stop until reset
				rep.illegal = 1'b1;
				arch_halted = 1'b1;
			end
		endcase
	endfunction

	function automatic exec_report_t predict_command(lc3ie_pkg::cmd_t c, word_t a,
			word_t d);
		exec_report_t rep;
		rep = '0;
		case (c)
			lc3ie_pkg::CMD_WRITE:  note_store(a, d);
			lc3ie_pkg::CMD_READ:   rep.read_word = mem_img[a];
			lc3ie_pkg::CMD_SET_PC: arch_pc = a;
			default: begin
				if (!arch_halted) begin
					run_instr(d, rep);
				end
			end
		endcase
		rep.pc_after = arch_pc;
		rep.flags_nzp = arch_nzp;
		rep.halted = arch_halted;
		return rep;
	endfunction

	// ------------------------------------------------------------------ checker

	task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_SHOWN) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want,
					got);
			end
		end
	endtask

	task automatic check_report(exec_report_t got);
		exec_report_t want;
		if (expected_reports.size() == 0) begin
			errors++;
			if (errors <= MAX_SHOWN) begin
				$display("%0t: result transfer with nothing pending, expected none, actual %h",
					$realtime, got);
			end
			return;
		end
		want = expected_reports.pop_front();
		n_checked++;
		cmp_field("pc_after", want.pc_after, got.pc_after);
		cmp_field("flags_nzp", 16'(want.flags_nzp), 16'(got.flags_nzp));
		cmp_field("read_word", want.read_word, got.read_word);
		cmp_field("reg_written", 16'(want.reg_written), 16'(got.reg_written));
		cmp_field("reg_number", 16'(want.reg_number), 16'(got.reg_number));
		cmp_field("reg_value", want.reg_value, got.reg_value);
		cmp_field("mem_written", 16'(want.mem_written), 16'(got.mem_written));
		cmp_field("store_address", want.store_address, got.store_address);
		cmp_field("store_value", want.store_value, got.store_value);
		cmp_field("illegal", 16'(want.illegal), 16'(got.illegal));
		cmp_field("halted", 16'(want.halted), 16'(got.halted));
	endtask

	// mostly short idle stretches, a few long ones
	function automatic int unsigned idle_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// receiver: checks each transfer, then picks tready for the next cycle
	initial begin : rx_side
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				check_report(exec_report_t'(m_axis_tdata));
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
				stall_left = idle_len() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: no progress within %0d cycles", $realtime, CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------- sender

	// one command transfer; tvalid stays high on return for back-to-back issue
	task automatic send_cmd(lc3ie_pkg::cmd_t c, word_t a, word_t d);
		int unsigned gap;
		gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// data, address, command from the top down
		s_axis_tdata <= {6'b0, d, a, c};
		s_axis_tvalid <= 1'b1;
		expected_reports.push_back(predict_command(c, a, d));
		n_sent++;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic word_t rand_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 16'h0000;
		end else if (r < 16) begin
			return 16'hFFFF;
		end else if (r < 20) begin
			return 16'h8000;
		end else if (r < 24) begin
			return 16'h7FFF;
		end
		return word_t'($urandom);
	endfunction

	function automatic word_t instr(lc3ie_pkg::opcode_t op, logic [11:0] body);
		return {op, body};
	endfunction

	// write a word first if it is about to be read and has never been written
	task automatic fill_word(word_t a);
		if (!mem_set[a]) begin
			send_cmd(lc3ie_pkg::CMD_WRITE, a, rand_word());
		end
	endtask

	task automatic send_exec(word_t ir);
		word_t ea_pc;
		ea_pc = arch_pc + 16'd1 + sx(ir, 9);
		if (!arch_halted) begin
			case (lc3ie_pkg::opcode_t'(ir[15:12]))
				lc3ie_pkg::OP_LD, lc3ie_pkg::OP_STI: fill_word(ea_pc);
				lc3ie_pkg::OP_LDI: begin
					fill_word(ea_pc);
					fill_word(mem_img[ea_pc]);
				end
				lc3ie_pkg::OP_LDR:  fill_word(arch_reg[ir[8:6]] + sx(ir, 6));
				lc3ie_pkg::OP_TRAP: fill_word({8'h00, ir[7:0]});
				default: ;
			endcase
		end
		send_cmd(lc3ie_pkg::CMD_EXEC, word_t'($urandom), ir);
	endtask

	task automatic send_random(bit legal_only);
		int unsigned        r;
		lc3ie_pkg::opcode_t op;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			send_cmd(lc3ie_pkg::CMD_WRITE, rand_word(), rand_word());
		end else if (r < 14 && written_addrs.size() != 0) begin
			send_cmd(lc3ie_pkg::CMD_READ,
				written_addrs[$urandom_range(0, written_addrs.size() - 1)],
				word_t'($urandom));
		end else if (r < 18) begin
			send_cmd(lc3ie_pkg::CMD_SET_PC, rand_word(), word_t'($urandom));
		end else begin
			do begin
				op = lc3ie_pkg::opcode_t'(4'($urandom_range(0, 15)));
			end while (legal_only && (op == lc3ie_pkg::OP_RTI || op == lc3ie_pkg::OP_RES));
			send_exec(instr(op, 12'($urandom)));
		end
	endtask

	// -------------------------------------------------------------------- tests

	// field extremes, every legal opcode and both addressing forms
	task automatic test_directed();
		send_cmd(lc3ie_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF);
		send_cmd(lc3ie_pkg::CMD_WRITE, 16'h0000, 16'h8000);
		send_cmd(lc3ie_pkg::CMD_READ, 16'hFFFF, 16'h0000);
		send_cmd(lc3ie_pkg::CMD_READ, 16'h0000, 16'hFFFF);
		// pc wraps past the top
		send_cmd(lc3ie_pkg::CMD_SET_PC, 16'hFFFF, 16'h0000);
		send_exec(instr(lc3ie_pkg::OP_ADD, {3'd1, 3'd0, 1'b1, 5'h1F}));
		send_exec(instr(lc3ie_pkg::OP_ADD, {3'd2, 3'd1, 1'b0, 2'b00, 3'd1}));
		send_exec(instr(lc3ie_pkg::OP_AND, {3'd3, 3'd1, 1'b1, 5'h00}));
		send_exec(instr(lc3ie_pkg::OP_ADD, {3'd4, 3'd3, 1'b1, 5'h0F}));
		send_exec(instr(lc3ie_pkg::OP_AND, {3'd5, 3'd1, 1'b0, 2'b00, 3'd4}));
		send_exec(instr(lc3ie_pkg::OP_NOT, {3'd6, 3'd4, 6'h3F}));
		// branch taken backward, then never
		send_exec(instr(lc3ie_pkg::OP_BR, {3'b111, 9'h100}));
		send_exec(instr(lc3ie_pkg::OP_BR, {3'b000, 9'h0FF}));
		send_exec(instr(lc3ie_pkg::OP_LEA, {3'd0, 9'h0FF}));
		// store then load back the same word
		send_exec(instr(lc3ie_pkg::OP_ST, {3'd6, 9'h1FF}));
		send_exec(instr(lc3ie_pkg::OP_LD, {3'd7, 9'h1FE}));
		send_exec(instr(lc3ie_pkg::OP_STR, {3'd1, 3'd5, 6'h20}));
		send_exec(instr(lc3ie_pkg::OP_LDR, {3'd2, 3'd5, 6'h1F}));
		// indirect store then indirect load through the same pointer
		send_exec(instr(lc3ie_pkg::OP_STI, {3'd4, 9'h000}));
		send_exec(instr(lc3ie_pkg::OP_LDI, {3'd3, 9'h1FF}));
		send_exec(instr(lc3ie_pkg::OP_JMP, {3'd0, 3'd1, 6'h00}));
		send_exec(instr(lc3ie_pkg::OP_JSR, {1'b1, 11'h3FF}));
		send_exec(instr(lc3ie_pkg::OP_JSR, {1'b0, 2'b00, 3'd2, 6'h00}));
		send_exec(instr(lc3ie_pkg::OP_TRAP, {4'h0, 8'h25}));
		send_exec(instr(lc3ie_pkg::OP_TRAP, {4'h0, 8'hFF}));
		drain();
	endtask

	// random programs under each combination of sender gaps and receiver stalls
	task automatic test_random_program();
		for (int phase = 0; phase < 4; phase++) begin
			tx_gaps_on = phase[0];
			rx_stalls_on = phase[1];
			for (int k = 0; k < 120; k++) begin
				send_random(1'b1);
			end
			drain();
		end
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_request = 150;
		for (int k = 0; k < 40; k++) begin
			send_random(1'b1);
		end
		drain();
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// illegal opcode halts; later executes do nothing, other commands still act
	task automatic test_halt();
		lc3ie_pkg::opcode_t first;
		lc3ie_pkg::opcode_t second;
		first = $urandom_range(0, 1) ? lc3ie_pkg::OP_RTI : lc3ie_pkg::OP_RES;
		second = (first == lc3ie_pkg::OP_RTI) ? lc3ie_pkg::OP_RES : lc3ie_pkg::OP_RTI;
		for (int k = 0; k < 20; k++) begin
			send_random(1'b1);
		end
		send_exec(instr(first, 12'($urandom)));
		send_exec(instr(second, 12'($urandom)));
		send_exec(instr(lc3ie_pkg::OP_ADD, {3'd1, 3'd1, 1'b1, 5'h01}));
		send_exec(instr(lc3ie_pkg::OP_LDI, 12'($urandom)));
		send_cmd(lc3ie_pkg::CMD_WRITE, 16'h1234, 16'hBEEF);
		send_cmd(lc3ie_pkg::CMD_READ, 16'h1234, 16'h0000);
		send_cmd(lc3ie_pkg::CMD_SET_PC, 16'h4321, 16'h0000);
		for (int k = 0; k < 20; k++) begin
			send_random(1'b0);
		end
		drain();
	endtask

	// ------------------------------------------------------------- main sequence

	initial begin : main_seq
		for (int k = 0; k < 8; k++) begin
			arch_reg[k] = '0;
		end
		arch_pc = '0;
		arch_nzp = lc3ie_pkg::FLAG_Z;
		arch_halted = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_program();
		test_backpressure();
		test_halt();

		// allow for any stray late result
		repeat (20) @(posedge clk);
		$display("covered %0d commands, %0d results checked: %0d executed instructions,",
			n_sent, n_checked, n_exec);
		$display("%0d register writes, %0d stores, long output hold-off and halt on illegal",
			n_reg_wr, n_store);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/lc3ie_pkg.sv
src/lc3ie_word_mem.sv
src/lc3ie_reg_file.sv
src/lc3_instruction_execute.sv
tb/sv/tb.sv
